>>> design/sqmp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the square matrix power block.
// No dependencies; used by sqmp_ctrl, sqmp_datapath and square_matrix_power.
package sqmp_pkg;

   localparam int ELEM_BITS = 32;   // element field width on the ports
   localparam int EXP_W     = 63;   // exponent field width
   localparam int DIM_W     = 3;    // dimension register width
   localparam int BIT_W     = 6;    // exponent bit counter width

   localparam logic [DIM_W-1:0] DIM_RESET  = 3'd4;
   localparam logic [BIT_W-1:0] EXP_TOP    = 6'(EXP_W - 1);
   localparam logic [1:0]       DRAIN_LAST = 2'd3;

   typedef struct packed {
      logic [ELEM_BITS-1:0] element;
      logic [EXP_W-1:0]     exponent;
      logic                 last_in;
   } req_payload_type;

   typedef struct packed {
      logic [ELEM_BITS-1:0] result_element;
      logic                 last_out;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_BIT,
      ST_SQUARE,
      ST_CHECK,
      ST_MULT,
      ST_DRAIN,
      ST_NEXT,
      ST_OUT_READ,
      ST_OUT_CAPTURE,
      ST_OUT_SEND
   } state_type;

   // Controller to datapath command flags
   typedef struct packed {
      logic base_we;    // store a loaded element into the base matrix
      logic issue;      // one multiply-accumulate term enters the pipeline
      logic rhs_base;   // right operand from the base matrix, else the accumulator
      logic ident;      // accumulator is still the identity
      logic diag;       // left operand position is on the diagonal
      logic first;      // first term of a dot product
      logic last;       // last term of a dot product
      logic out_cap;    // capture the read element for the result beat
      logic flip;       // swap accumulator banks
   } ctl_cmd_type;

endpackage

>>> design/sqmp_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the square matrix power block: load, square-and-multiply, unload.
// Depends on sqmp_pkg; drives sqmp_datapath through command flags and addresses.
module sqmp_ctrl #(
   parameter int MAX_DIM = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_last_in,
   input  logic [sqmp_pkg::EXP_W-1:0]   req_exponent,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_last,
   input  logic                         csr_we,
   input  logic [sqmp_pkg::DIM_W-1:0]   csr_wdata,
   output sqmp_pkg::ctl_cmd_type        cmd,
   output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] base_waddr,
   output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] lhs_addr,
   output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rhs_addr,
   output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] wr_addr
);

   localparam int CELLS = MAX_DIM * MAX_DIM;
   localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int PW    = $clog2(CELLS + 1);
   localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int NW    = $clog2(MAX_DIM + 1);

   sqmp_pkg::state_type state_ff, state_in;

   logic [sqmp_pkg::DIM_W-1:0] dim_ff, dim_in;
   logic [PW-1:0]              load_pos_ff, load_pos_in;
   logic [sqmp_pkg::EXP_W-1:0] exp_ff, exp_in;
   logic [sqmp_pkg::BIT_W-1:0] bit_ff, bit_in;
   logic                       ident_ff, ident_in;
   logic                       mul_phase_ff, mul_phase_in;
   logic [1:0]                 drain_ff, drain_in;
   logic [IW-1:0]              i_ff, i_in, j_ff, j_in, k_ff, k_in;

   logic [NW-1:0] n;
   logic [IW-1:0] nm1;
   logic [PW-1:0] cells;
   logic          load_room;
   logic          req_fire;
   logic          mac_done;
   logic          out_last;

   function automatic logic [CW-1:0] lin(input logic [IW-1:0] r, input logic [IW-1:0] c,
                                         input logic [NW-1:0] dim);
      lin = CW'(int'(r) * int'(dim) + int'(c));
   endfunction

   // Clamp the programmed dimension to 1..MAX_DIM
   always_comb begin
      if (dim_ff == '0) begin
         n = NW'(1);
      end else if (int'(dim_ff) > MAX_DIM) begin
         n = NW'(MAX_DIM);
      end else begin
         n = NW'(dim_ff);
      end
   end

   assign nm1       = IW'(int'(n) - 1);
   assign cells     = PW'(int'(n) * int'(n));
   assign load_room = (load_pos_ff < cells);
   assign req_fire  = req_valid && req_ready;
   assign mac_done  = (i_ff == nm1) && (j_ff == nm1) && (k_ff == nm1);
   assign out_last  = (i_ff == nm1) && (j_ff == nm1);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sqmp_pkg::ST_LOAD: begin
            if (req_valid && req_last_in) state_in = sqmp_pkg::ST_BIT;
         end
         sqmp_pkg::ST_BIT: begin
            state_in = ident_ff ? sqmp_pkg::ST_CHECK : sqmp_pkg::ST_SQUARE;
         end
         sqmp_pkg::ST_SQUARE, sqmp_pkg::ST_MULT: begin
            if (mac_done) state_in = sqmp_pkg::ST_DRAIN;
         end
         sqmp_pkg::ST_CHECK: begin
            state_in = exp_ff[sqmp_pkg::EXP_W-1] ? sqmp_pkg::ST_MULT : sqmp_pkg::ST_NEXT;
         end
         sqmp_pkg::ST_DRAIN: begin
            if (drain_ff == sqmp_pkg::DRAIN_LAST) begin
               state_in = mul_phase_ff ? sqmp_pkg::ST_NEXT : sqmp_pkg::ST_CHECK;
            end
         end
         sqmp_pkg::ST_NEXT: begin
            state_in = (bit_ff == '0) ? sqmp_pkg::ST_OUT_READ : sqmp_pkg::ST_BIT;
         end
         sqmp_pkg::ST_OUT_READ:    state_in = sqmp_pkg::ST_OUT_CAPTURE;
         sqmp_pkg::ST_OUT_CAPTURE: state_in = sqmp_pkg::ST_OUT_SEND;
         sqmp_pkg::ST_OUT_SEND: begin
            if (rsp_ready) state_in = out_last ? sqmp_pkg::ST_LOAD : sqmp_pkg::ST_OUT_READ;
         end
         default: state_in = sqmp_pkg::ST_LOAD;
      endcase
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      req_ready  = (state_ff == sqmp_pkg::ST_LOAD);
      rsp_valid  = (state_ff == sqmp_pkg::ST_OUT_SEND);
      rsp_last   = out_last;
      base_waddr = CW'(load_pos_ff);
      rhs_addr   = lin(k_ff, j_ff, n);
      wr_addr    = lin(i_ff, j_ff, n);
      lhs_addr   = lin(i_ff, k_ff, n);
      unique case (state_ff)
         sqmp_pkg::ST_LOAD: begin
            cmd.base_we = req_valid && load_room;
         end
         sqmp_pkg::ST_SQUARE, sqmp_pkg::ST_MULT: begin
            cmd.issue    = 1'b1;
            cmd.rhs_base = (state_ff == sqmp_pkg::ST_MULT);
            cmd.ident    = ident_ff;
            cmd.diag     = (i_ff == k_ff);
            cmd.first    = (k_ff == '0);
            cmd.last     = (k_ff == nm1);
         end
         sqmp_pkg::ST_DRAIN: begin
            cmd.flip = (drain_ff == sqmp_pkg::DRAIN_LAST);
         end
         sqmp_pkg::ST_OUT_READ: begin
            lhs_addr  = lin(i_ff, j_ff, n);
            cmd.ident = ident_ff;
            cmd.diag  = (i_ff == j_ff);
         end
         sqmp_pkg::ST_OUT_CAPTURE: begin
            cmd.out_cap = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Dimension register, datapath counters, exponent and load position
   always_comb begin
      dim_in       = csr_we ? csr_wdata : dim_ff;
      load_pos_in  = load_pos_ff;
      exp_in       = exp_ff;
      bit_in       = bit_ff;
      ident_in     = ident_ff;
      mul_phase_in = mul_phase_ff;
      drain_in     = drain_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      unique case (state_ff)
         sqmp_pkg::ST_LOAD: begin
            i_in = '0;
            j_in = '0;
            k_in = '0;
            if (req_fire) begin
               if (req_last_in) begin
                  load_pos_in = '0;
                  exp_in      = req_exponent;
                  bit_in      = sqmp_pkg::EXP_TOP;
                  ident_in    = 1'b1;
               end else if (load_room) begin
                  load_pos_in = load_pos_ff + PW'(1);
               end
            end
         end
         sqmp_pkg::ST_SQUARE, sqmp_pkg::ST_MULT: begin
            mul_phase_in = (state_ff == sqmp_pkg::ST_MULT);
            if (k_ff == nm1) begin
               k_in = '0;
               if (j_ff == nm1) begin
                  j_in = '0;
                  i_in = (i_ff == nm1) ? '0 : i_ff + IW'(1);
               end else begin
                  j_in = j_ff + IW'(1);
               end
            end else begin
               k_in = k_ff + IW'(1);
            end
         end
         sqmp_pkg::ST_DRAIN: begin
            if (drain_ff == sqmp_pkg::DRAIN_LAST) begin
               drain_in = '0;
               if (mul_phase_ff) ident_in = 1'b0;
            end else begin
               drain_in = drain_ff + 2'd1;
            end
         end
         sqmp_pkg::ST_NEXT: begin
            exp_in = {exp_ff[sqmp_pkg::EXP_W-2:0], 1'b0};
            if (bit_ff != '0) bit_in = bit_ff - sqmp_pkg::BIT_W'(1);
         end
         sqmp_pkg::ST_OUT_SEND: begin
            if (rsp_ready) begin
               if (j_ff == nm1) begin
                  j_in = '0;
                  i_in = (i_ff == nm1) ? '0 : i_ff + IW'(1);
               end else begin
                  j_in = j_ff + IW'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sqmp_pkg::ST_LOAD;
         dim_ff       <= sqmp_pkg::DIM_RESET;
         load_pos_ff  <= '0;
         exp_ff       <= '0;
         bit_ff       <= '0;
         ident_ff     <= 1'b0;
         mul_phase_ff <= 1'b0;
         drain_ff     <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         dim_ff       <= dim_in;
         load_pos_ff  <= load_pos_in;
         exp_ff       <= exp_in;
         bit_ff       <= bit_in;
         ident_ff     <= ident_in;
         mul_phase_ff <= mul_phase_in;
         drain_ff     <= drain_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
      end
   end

   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_last_in) |=>
         (state_ff == sqmp_pkg::ST_BIT && ident_ff && load_pos_ff == '0))
      else $error("computation did not start cleanly after the last load beat");

   a_no_square_ident: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sqmp_pkg::ST_SQUARE) |-> !ident_ff)
      else $error("squaring issued while the accumulator is the identity");

   a_drain_state: assert property (@(posedge clock) disable iff (reset)
      (drain_ff != '0) |-> (state_ff == sqmp_pkg::ST_DRAIN))
      else $error("drain counter running outside the drain state");

endmodule

>>> design/sqmp_datapath.sv
`timescale 1ns / 1ps
// Matrix stores and the shared multiply-accumulate pipeline.
// Depends on sqmp_pkg; commanded by sqmp_ctrl.
module sqmp_datapath #(
   parameter int MAX_DIM    = 4,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  sqmp_pkg::ctl_cmd_type            cmd,
   input  logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] base_waddr,
   input  logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] lhs_addr,
   input  logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rhs_addr,
   input  logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] wr_addr,
   input  logic [sqmp_pkg::ELEM_BITS-1:0]   elem_in,
   output logic [sqmp_pkg::ELEM_BITS-1:0]   result_element
);

   localparam int CELLS = MAX_DIM * MAX_DIM;
   localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int AW    = $clog2(2 * CELLS);
   localparam int W     = ELEM_WIDTH;
   localparam int H     = (W + 1) / 2;
   localparam int L     = W - H;

   logic [W-1:0] base_mem [CELLS];
   logic [W-1:0] acc_mem  [2*CELLS];

   logic          bank_ff;
   logic [AW-1:0] rd_a_idx, rd_b_idx, wr_idx;

   logic [W-1:0] rd_a_ff, rd_b_ff, rd_base_ff;
   logic [W-1:0] out_ff;

   logic          s1_valid_ff, s1_first_ff, s1_last_ff, s1_ident_ff, s1_diag_ff, s1_rhs_base_ff;
   logic [CW-1:0] s1_waddr_ff;
   logic          s2_valid_ff, s2_first_ff, s2_last_ff;
   logic [CW-1:0] s2_waddr_ff;
   logic          s3_valid_ff, s3_first_ff, s3_last_ff;
   logic [CW-1:0] s3_waddr_ff;

   logic [W-1:0]   lhs_val, rhs_val;
   logic [2*H-1:0] ll_ff, ll_in;
   logic [L-1:0]   lh_ff, lh_in, hl_ff, hl_in;
   logic [L-1:0]   cross_sum;
   logic [W-1:0]   prod_ff, prod_in;
   logic [W-1:0]   mac_ff, mac_in;

   // Reads come from the current bank, products go to the other one
   assign rd_a_idx = bank_ff ? AW'(lhs_addr) + AW'(CELLS) : AW'(lhs_addr);
   assign rd_b_idx = bank_ff ? AW'(rhs_addr) + AW'(CELLS) : AW'(rhs_addr);
   assign wr_idx   = bank_ff ? AW'(s3_waddr_ff) : AW'(s3_waddr_ff) + AW'(CELLS);

   always_ff @(posedge clock) begin
      if (cmd.base_we) base_mem[base_waddr] <= W'(elem_in);
      rd_base_ff <= base_mem[rhs_addr];
   end

   always_ff @(posedge clock) begin
      if (s3_valid_ff && s3_last_ff) acc_mem[wr_idx] <= mac_in;
      rd_a_ff <= acc_mem[rd_a_idx];
      rd_b_ff <= acc_mem[rd_b_idx];
   end

   // Identity accumulator is substituted on the left operand
   assign lhs_val = s1_ident_ff ? W'(s1_diag_ff) : rd_a_ff;
   assign rhs_val = s1_rhs_base_ff ? rd_base_ff : rd_b_ff;

   // Split product: only the low W bits of the full product are kept
   assign ll_in     = (2*H)'(lhs_val[H-1:0]) * (2*H)'(rhs_val[H-1:0]);
   assign lh_in     = L'(lhs_val[H-1:0] * H'(rhs_val[W-1:H]));
   assign hl_in     = L'(H'(lhs_val[W-1:H]) * rhs_val[H-1:0]);
   assign cross_sum = lh_ff + hl_ff;
   assign prod_in   = W'(ll_ff) + {cross_sum, {H{1'b0}}};
   assign mac_in    = (s3_first_ff ? '0 : mac_ff) + prod_ff;

   always_ff @(posedge clock) begin
      s1_first_ff    <= cmd.first;
      s1_last_ff     <= cmd.last;
      s1_ident_ff    <= cmd.ident;
      s1_diag_ff     <= cmd.diag;
      s1_rhs_base_ff <= cmd.rhs_base;
      s1_waddr_ff    <= wr_addr;
      ll_ff          <= ll_in;
      lh_ff          <= lh_in;
      hl_ff          <= hl_in;
      s2_first_ff    <= s1_first_ff;
      s2_last_ff     <= s1_last_ff;
      s2_waddr_ff    <= s1_waddr_ff;
      prod_ff        <= prod_in;
      s3_first_ff    <= s2_first_ff;
      s3_last_ff     <= s2_last_ff;
      s3_waddr_ff    <= s2_waddr_ff;
      if (s3_valid_ff) mac_ff <= mac_in;
      if (cmd.out_cap) out_ff <= lhs_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (cmd.flip) bank_ff <= ~bank_ff;
         s1_valid_ff <= cmd.issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   assign result_element = sqmp_pkg::ELEM_BITS'(out_ff);

   a_flip_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.flip |-> !(s1_valid_ff || s2_valid_ff || s3_valid_ff))
      else $error("bank swap while products are still in the pipeline");

   a_cap_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.out_cap |-> !(s1_valid_ff || s2_valid_ff || s3_valid_ff))
      else $error("result capture overlaps multiply-accumulate work");

endmodule

>>> design/square_matrix_power.sv
`timescale 1ns / 1ps
// Square matrix power: loads a matrix beat by beat and emits its power.
// Depends on sqmp_pkg, sqmp_ctrl and sqmp_datapath.
//
// Load n*n element beats in row-major order (n is the dimension register,
// clamped to 1..MAX_DIM); the beat with last_in set also carries the exponent
// and starts the computation. Load beats can be accepted back to back. The
// power is formed by square-and-multiply from exponent bit 62 down through
// one shared multiply-accumulate pipeline: each bit passes through the control
// states, plus a squaring once the accumulator has left the identity, plus a
// multiply by the base when the bit is set. The leading zero bits pass
// through the control states only. The result is then sent as n*n beats, each
// passing through the memory read, capture and send states, the final one
// marked with last_out. No new load beat is accepted from the start of the
// computation until the final result beat is taken.
module square_matrix_power #(
   parameter int MAX_DIM    = 4,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  sqmp_pkg::req_payload_type        req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output sqmp_pkg::rsp_payload_type        rsp_data,
   input  logic                             csr_we,
   input  logic [sqmp_pkg::DIM_W-1:0]       csr_wdata
);

   localparam int CELLS = MAX_DIM * MAX_DIM;
   localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;

   sqmp_pkg::ctl_cmd_type cmd;
   logic [CW-1:0]         base_waddr, lhs_addr, rhs_addr, wr_addr;
   logic                  rsp_last;
   logic [sqmp_pkg::ELEM_BITS-1:0] result_element;

   sqmp_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_last_in  (req_data.last_in),
      .req_exponent (req_data.exponent),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_last     (rsp_last),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .base_waddr   (base_waddr),
      .lhs_addr     (lhs_addr),
      .rhs_addr     (rhs_addr),
      .wr_addr      (wr_addr)
   );

   sqmp_datapath #(
      .MAX_DIM    (MAX_DIM),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .base_waddr     (base_waddr),
      .lhs_addr       (lhs_addr),
      .rhs_addr       (rhs_addr),
      .wr_addr        (wr_addr),
      .elem_in        (req_data.element),
      .result_element (result_element)
   );

   assign rsp_data.result_element = result_element;
   assign rsp_data.last_out       = rsp_last;

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Testbench for square_matrix_power: matrix beats in, powered matrix beats out.
// Depends on sqmp_pkg and the square_matrix_power RTL; predicts every result
// with its own square-and-multiply model and checks the beats in order.
module tb;

   localparam int CELL_COUNT  = 16;
   localparam int QUIET_LIMIT = 40000;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   sqmp_pkg::req_payload_type       req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   sqmp_pkg::rsp_payload_type       rsp_data;
   logic                            csr_we = 1'b0;
   logic [sqmp_pkg::DIM_W-1:0]      csr_wdata = '0;

   // Predictor state
   logic [sqmp_pkg::ELEM_BITS-1:0]  base_grid [CELL_COUNT];
   logic [sqmp_pkg::ELEM_BITS-1:0]  acc_grid  [CELL_COUNT];
   logic [sqmp_pkg::ELEM_BITS-1:0]  prod_grid [CELL_COUNT];
   bit                              cell_written [CELL_COUNT];
   int                              load_slot = 0;
   logic [sqmp_pkg::DIM_W-1:0]      dim_setting = sqmp_pkg::DIM_RESET;

   sqmp_pkg::rsp_payload_type       power_queue [$];
   int                              mismatch_count = 0;
   int unsigned                     req_gap = 0;
   bit                              req_steady = 1'b1;
   bit                              rsp_steady = 1'b1;
   int unsigned                     rsp_hold = 0;
   int unsigned                     quiet_cycles = 0;

   square_matrix_power dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int active_size();
      if (dim_setting == 0) return 1;
      if (dim_setting > 4) return 4;
      return int'(dim_setting);
   endfunction

   // acc = acc * (base or acc), wrapping at the element width
   task automatic multiply_into_acc(input bit by_base, input int n);
      logic [sqmp_pkg::ELEM_BITS-1:0] sum;
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            sum = '0;
            for (int k = 0; k < n; k++)
               sum += acc_grid[i*n+k] * (by_base ? base_grid[k*n+j] : acc_grid[k*n+j]);
            prod_grid[i*n+j] = sum;
         end
      end
      for (int i = 0; i < CELL_COUNT; i++) acc_grid[i] = prod_grid[i];
   endtask

   task automatic predict_beat(input sqmp_pkg::req_payload_type beat);
      int n;
      int cells;
      sqmp_pkg::rsp_payload_type out_beat;
      n = active_size();
      cells = n * n;
      if (load_slot < cells) begin
         base_grid[load_slot] = beat.element;
         cell_written[load_slot] = 1'b1;
         load_slot++;
      end
      if (beat.last_in) begin
         for (int i = 0; i < CELL_COUNT; i++) acc_grid[i] = '0;
         for (int i = 0; i < n; i++) acc_grid[i*n+i] = 1;
         for (int b = sqmp_pkg::EXP_W - 1; b >= 0; b--) begin
            multiply_into_acc(1'b0, n);
            if (beat.exponent[b]) multiply_into_acc(1'b1, n);
         end
         load_slot = 0;
         for (int i = 0; i < cells; i++) begin
            out_beat.result_element = acc_grid[i];
            out_beat.last_out = (i == cells - 1);
            power_queue.push_back(out_beat);
         end
      end
   endtask

   function automatic int unsigned pick_wait(input bit steady);
      return steady ? 0 : $urandom_range(0, 10);
   endfunction

   function automatic sqmp_pkg::req_payload_type make_beat(
      input logic [sqmp_pkg::ELEM_BITS-1:0] element,
      input logic [sqmp_pkg::EXP_W-1:0]     exponent,
      input logic                           last_in);
      sqmp_pkg::req_payload_type beat;
      beat.element = element;
      beat.exponent = exponent;
      beat.last_in = last_in;
      return beat;
   endfunction

   task automatic send_beat(input sqmp_pkg::req_payload_type beat);
      if (req_gap > 0) repeat (req_gap) @(posedge clock);
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (!req_ready);
      predict_beat(beat);
      req_gap = pick_wait(req_steady);
      if (req_gap > 0) req_valid <= 1'b0;
   endtask

   // Drop valid if the last beat left it up for a back-to-back follower
   task automatic hold_sender();
      if (req_gap == 0) begin
         req_valid <= 1'b0;
         req_gap = 1;
      end
   endtask

   task automatic drain_results();
      hold_sender();
      while (power_queue.size() != 0) @(posedge clock);
   endtask

   task automatic set_dimension(input logic [sqmp_pkg::DIM_W-1:0] value);
      drain_results();
      repeat (10) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      dim_setting = value;
   endtask

   function automatic logic [sqmp_pkg::ELEM_BITS-1:0] pick_element();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [sqmp_pkg::EXP_W-1:0] scrambled_exponent();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[sqmp_pkg::EXP_W-1:0];
   endfunction

   function automatic logic [sqmp_pkg::EXP_W-1:0] pick_power();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 1;
         2: return $urandom_range(2, 40);
         default: return scrambled_exponent() >> $urandom_range(0, sqmp_pkg::EXP_W - 1);
      endcase
   endfunction

   function automatic bit cells_stored(input int from_cell, input int to_cell);
      for (int i = from_cell; i < to_cell; i++)
         if (!cell_written[i]) return 1'b0;
      return 1'b1;
   endfunction

   // One matrix: mostly well formed, some cut short, some overfilled
   task automatic send_matrix(output int sent);
      int cells;
      int len;
      int shape;
      logic [sqmp_pkg::EXP_W-1:0] power;
      cells = active_size() * active_size();
      shape = $urandom_range(0, 9);
      power = pick_power();
      len = cells;
      if (shape < 2 && cells > 1) begin
         len = $urandom_range(1, cells - 1);
         // never let the block multiply by a cell that holds nothing yet
         if (!cells_stored(len, cells)) len = cells;
      end else if (shape < 4) begin
         len = cells + $urandom_range(1, 3);
      end
      for (int i = 0; i < len; i++) begin
         if (i == len - 1) send_beat(make_beat(pick_element(), power, 1'b1));
         else send_beat(make_beat(pick_element(), scrambled_exponent(), 1'b0));
      end
      sent = len;
   endtask

   task automatic test_single_cell();
      req_steady = 1'b1;
      set_dimension(3'd1);
      send_beat(make_beat('1, '0, 1'b1));
      send_beat(make_beat('1, 2, 1'b1));
      send_beat(make_beat(3, '1, 1'b1));
      send_beat(make_beat('0, 5, 1'b1));
      send_beat(make_beat(32'h8000_0000, 1, 1'b1));
   endtask

   task automatic test_dimension_zero();
      req_steady = 1'b0;
      set_dimension(3'd0);
      send_beat(make_beat(32'h1234_5679, 3, 1'b1));
   endtask

   // Extra beats past a full matrix are dropped, the last one's element too
   task automatic test_excess_elements();
      req_steady = 1'b1;
      set_dimension(3'd2);
      send_beat(make_beat(1, '0, 1'b0));
      send_beat(make_beat(2, '1, 1'b0));
      send_beat(make_beat(3, '0, 1'b0));
      send_beat(make_beat(4, '1, 1'b0));
      send_beat(make_beat(32'hDEAD_BEEF, '0, 1'b0));
      send_beat(make_beat('1, '1, 1'b0));
      send_beat(make_beat(7, 3, 1'b1));
   endtask

   // Short matrix: the unloaded cell keeps its earlier value
   task automatic test_early_last();
      req_steady = 1'b0;
      send_beat(make_beat(5, '0, 1'b0));
      send_beat(make_beat(6, '0, 1'b0));
      send_beat(make_beat(7, 2, 1'b1));
      drain_results();
   endtask

   task automatic test_alternating_power();
      req_steady = 1'b1;
      send_beat(make_beat('1, '0, 1'b0));
      send_beat(make_beat(32'hAAAA_AAAA, '0, 1'b0));
      send_beat(make_beat(32'h5555_5555, '0, 1'b0));
      send_beat(make_beat(3, 63'h2AAA_AAAA_AAAA_AAAA, 1'b1));
   endtask

   function automatic logic [sqmp_pkg::DIM_W-1:0] plan_dim(input int phase);
      case (phase)
         0: return 3'd4;
         1: return 3'd1;
         2: return 3'd2;
         3: return 3'd3;
         4: return 3'd0;
         5: return 3'd5;
         6: return 3'd2;
         7: return 3'd7;
         8: return 3'd1;
         9: return 3'd3;
         default: return 3'd6;
      endcase
   endfunction

   task automatic test_random_traffic();
      int phase_beats;
      int sent;
      for (int phase = 0; phase < 11; phase++) begin
         set_dimension(plan_dim(phase));
         phase_beats = 0;
         while (phase_beats < 20) begin
            req_steady = ($urandom_range(0, 3) == 0);
            rsp_steady = ($urandom_range(0, 3) == 0);
            send_matrix(sent);
            phase_beats += sent;
            if ($urandom_range(0, 5) == 0) drain_results();
         end
      end
   endtask

   // Result side: random backpressure, check each beat against the oldest prediction
   always @(posedge clock) begin : result_sink
      int unsigned stall;
      sqmp_pkg::rsp_payload_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (power_queue.size() == 0) begin
            $display("%0t: unexpected result beat %h last %b", $time,
                     rsp_data.result_element, rsp_data.last_out);
            mismatch_count++;
         end else begin
            want = power_queue.pop_front();
            if (rsp_data.result_element !== want.result_element) begin
               $display("%0t: result_element expected %h actual %h", $time,
                        want.result_element, rsp_data.result_element);
               mismatch_count++;
            end
            if (rsp_data.last_out !== want.last_out) begin
               $display("%0t: last_out expected %b actual %b", $time,
                        want.last_out, rsp_data.last_out);
               mismatch_count++;
            end
         end
         stall = pick_wait(rsp_steady);
         rsp_ready <= (stall == 0);
         rsp_hold <= stall;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_ready <= (rsp_hold == 1);
      end else if (!rsp_steady && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         rsp_hold <= $urandom_range(1, 10);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_single_cell();
      test_dimension_zero();
      test_excess_elements();
      test_early_last();
      test_alternating_power();
      test_random_traffic();
      drain_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
